// File: src/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// checked at every edge, reset included
`define LNGH_CHK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
// checked only while out of reset
`define LNGH_CHK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define LNGH_CHK(lbl, clk, prop, msg)
`define LNGH_CHK_RST(lbl, clk, rst_n, prop, msg)
`endif

`endif

// File: src/lngh_pkg.sv
package lngh_pkg;

    localparam int COUNT_WIDTH   = 24;
    localparam int ALPHABET_SIZE = 26;
    localparam int BI_SIZE       = ALPHABET_SIZE * ALPHABET_SIZE;
    localparam int TRI_SIZE      = BI_SIZE * ALPHABET_SIZE;

    localparam int UNI_AW = $clog2(ALPHABET_SIZE);
    localparam int BI_AW  = $clog2(BI_SIZE);
    localparam int TRI_AW = $clog2(TRI_SIZE);

    localparam int OUT_COUNT_W = 24;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_COUNT_W - 1;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    localparam t_count COUNT_MAX = '1;

    localparam logic [7:0] LETTER_BASE = 8'd97;   // 'a'
    localparam logic [7:0] LETTER_LAST = 8'd122;  // 'z'

    typedef enum logic [1:0] {
        OP_TEXT  = 2'd0,
        OP_BREAK = 2'd1,
        OP_READ  = 2'd2,
        OP_RSVD  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ORD_NONE = 2'd0,
        ORD_UNI  = 2'd1,
        ORD_BI   = 2'd2,
        ORD_TRI  = 2'd3
    } t_order;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_READ
    } t_state;

endpackage

// File: src/letter_ngram_histogram_core.sv
// channel   | dir | tdata fields (lowest bit first)
// s_axis    | in  | opcode[1:0] char_byte[9:2] gram_order[11:10] gram_index[26:12]
// m_axis    | out | count_value[23:0] index_invalid[24]
//
// a letter byte is handled in IDLE, where the counters are read, then in UPDATE, where they
// are incremented and written back; line breaks, other bytes and opcode 3 need IDLE alone;
// a read goes through IDLE and then READ, which waits for the output register to be taken
// after reset a clearing pass over all 17576 trigram addresses zeroes the counter memories, tready low
// the output register lets letters keep flowing while a read result waits in it; a further read waits in READ

`include "assert_macros.svh"

module letter_ngram_histogram_core
    import lngh_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // opcode, char_byte, gram_order, gram_index
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // count_value, index_invalid
);

    t_state              r_state, n_state;
    logic [TRI_AW-1:0]   r_clr_addr;

    logic [UNI_AW-1:0]   r_prev_letter, r_prev2_letter;
    logic                r_prev_valid, r_prev2_valid;

    logic [UNI_AW-1:0]   r_uni_addr;
    logic [BI_AW-1:0]    r_bi_addr;
    logic [TRI_AW-1:0]   r_tri_addr;
    logic                r_do_bi, r_do_tri;
    t_order              r_rd_order;
    logic                r_rd_bad;

    logic                r_out_valid;
    t_count              r_out_count;
    logic                r_out_bad;

    t_opcode             in_op;
    logic [7:0]          in_char;
    t_order              in_order;
    logic [TRI_AW-1:0]   in_index;
    logic                accept;
    logic                is_letter;
    logic [UNI_AW-1:0]   letter;
    logic                idx_bad;

    logic [UNI_AW-1:0]   uni_rd_addr;
    logic [BI_AW-1:0]    bi_rd_addr;
    logic [TRI_AW-1:0]   tri_rd_addr;

    logic                uni_we, bi_we, tri_we;
    logic [UNI_AW-1:0]   uni_wa;
    logic [BI_AW-1:0]    bi_wa;
    logic [TRI_AW-1:0]   tri_wa;
    t_count              uni_wd, bi_wd, tri_wd;
    t_count              uni_rd, bi_rd, tri_rd;
    t_count              uni_inc, bi_inc, tri_inc;
    t_count              rd_sel;
    logic                out_load;

    assign in_op    = t_opcode'(s_axis_tdata[1:0]);
    assign in_char  = s_axis_tdata[9:2];
    assign in_order = t_order'(s_axis_tdata[11:10]);
    assign in_index = s_axis_tdata[26:12];
    assign accept   = s_axis_tvalid && s_axis_tready;

    assign is_letter = (in_char >= LETTER_BASE) && (in_char <= LETTER_LAST);
    assign letter    = UNI_AW'(in_char - LETTER_BASE);

    always_comb begin
        case (in_order)
            ORD_UNI: idx_bad = !(in_index < TRI_AW'(ALPHABET_SIZE));
            ORD_BI:  idx_bad = !(in_index < TRI_AW'(BI_SIZE));
            ORD_TRI: idx_bad = !(in_index < TRI_AW'(TRI_SIZE));
            default: idx_bad = 1'b1;
        endcase
    end

    // read addresses: the request's index for a read, the letter history otherwise
    always_comb begin
        if (in_op == OP_READ) begin
            uni_rd_addr = in_index[UNI_AW-1:0];
            bi_rd_addr  = in_index[BI_AW-1:0];
            tri_rd_addr = in_index;
        end else begin
            uni_rd_addr = letter;
            bi_rd_addr  = BI_AW'(BI_AW'(r_prev_letter) * BI_AW'(ALPHABET_SIZE))
                        + BI_AW'(letter);
            tri_rd_addr = TRI_AW'(TRI_AW'(r_prev2_letter) * TRI_AW'(BI_SIZE))
                        + TRI_AW'(TRI_AW'(r_prev_letter) * TRI_AW'(ALPHABET_SIZE))
                        + TRI_AW'(letter);
        end
    end

    // saturating increments of the values just read
    assign uni_inc = (uni_rd == COUNT_MAX) ? uni_rd : uni_rd + 1'b1;
    assign bi_inc  = (bi_rd  == COUNT_MAX) ? bi_rd  : bi_rd  + 1'b1;
    assign tri_inc = (tri_rd == COUNT_MAX) ? tri_rd : tri_rd + 1'b1;

    always_comb begin
        case (r_rd_order)
            ORD_UNI: rd_sel = uni_rd;
            ORD_BI:  rd_sel = bi_rd;
            ORD_TRI: rd_sel = tri_rd;
            default: rd_sel = '0;
        endcase
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        uni_we        = 1'b0;
        bi_we         = 1'b0;
        tri_we        = 1'b0;
        uni_wa        = r_uni_addr;
        bi_wa         = r_bi_addr;
        tri_wa        = r_tri_addr;
        uni_wd        = uni_inc;
        bi_wd         = bi_inc;
        tri_wd        = tri_inc;
        out_load      = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                uni_we = r_clr_addr < TRI_AW'(ALPHABET_SIZE);
                bi_we  = r_clr_addr < TRI_AW'(BI_SIZE);
                tri_we = 1'b1;
                uni_wa = r_clr_addr[UNI_AW-1:0];
                bi_wa  = r_clr_addr[BI_AW-1:0];
                tri_wa = r_clr_addr;
                uni_wd = '0;
                bi_wd  = '0;
                tri_wd = '0;
                if (r_clr_addr == TRI_AW'(TRI_SIZE - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (accept && in_op == OP_TEXT && is_letter) begin
                    n_state = ST_UPDATE;
                end else if (accept && in_op == OP_READ) begin
                    n_state = ST_READ;
                end
            end
            ST_UPDATE: begin
                uni_we  = 1'b1;
                bi_we   = r_do_bi;
                tri_we  = r_do_tri;
                n_state = ST_IDLE;
            end
            ST_READ: begin
                // hold the read data until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // letter history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_letter  <= '0;
            r_prev2_letter <= '0;
            r_prev_valid   <= 1'b0;
            r_prev2_valid  <= 1'b0;
        end else if (accept) begin
            if (in_op == OP_TEXT && is_letter) begin
                r_prev2_letter <= r_prev_letter;
                r_prev2_valid  <= r_prev_valid;
                r_prev_letter  <= letter;
                r_prev_valid   <= 1'b1;
            end else if (in_op == OP_TEXT || in_op == OP_BREAK) begin
                r_prev_letter  <= '0;
                r_prev2_letter <= '0;
                r_prev_valid   <= 1'b0;
                r_prev2_valid  <= 1'b0;
            end
        end
    end

    // request context kept for the write-back or the result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_uni_addr <= uni_rd_addr;
            r_bi_addr  <= bi_rd_addr;
            r_tri_addr <= tri_rd_addr;
            r_do_bi    <= r_prev_valid;
            r_do_tri   <= r_prev_valid && r_prev2_valid;
            r_rd_order <= in_order;
            r_rd_bad   <= idx_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_count <= r_rd_bad ? '0 : rd_sel;
            r_out_bad   <= r_rd_bad;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_bad, OUT_COUNT_W'(r_out_count)};

    lngh_ram #(.DEPTH(ALPHABET_SIZE), .WIDTH(COUNT_WIDTH)) u_uni_ram (
        .i_clk     (i_clk),
        .i_wr_en   (uni_we),
        .i_wr_addr (uni_wa),
        .i_wr_data (uni_wd),
        .i_rd_en   (accept),
        .i_rd_addr (uni_rd_addr),
        .o_rd_data (uni_rd)
    );

    lngh_ram #(.DEPTH(BI_SIZE), .WIDTH(COUNT_WIDTH)) u_bi_ram (
        .i_clk     (i_clk),
        .i_wr_en   (bi_we),
        .i_wr_addr (bi_wa),
        .i_wr_data (bi_wd),
        .i_rd_en   (accept),
        .i_rd_addr (bi_rd_addr),
        .o_rd_data (bi_rd)
    );

    lngh_ram #(.DEPTH(TRI_SIZE), .WIDTH(COUNT_WIDTH)) u_tri_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tri_we),
        .i_wr_addr (tri_wa),
        .i_wr_data (tri_wd),
        .i_rd_en   (accept),
        .i_rd_addr (tri_rd_addr),
        .o_rd_data (tri_rd)
    );

    `LNGH_CHK(a_no_req_while_clearing, i_clk, (r_state == ST_CLEAR) |-> !s_axis_tready, "request taken during clearing pass")
    `LNGH_CHK_RST(a_update_one_cycle, i_clk, i_rst_n, (r_state == ST_UPDATE) |=> (r_state == ST_IDLE), "write-back did not return to idle")
    `LNGH_CHK_RST(a_bad_index_zero, i_clk, i_rst_n, (m_axis_tvalid && r_out_bad) |-> (r_out_count == '0), "invalid index with nonzero count")
    `LNGH_CHK_RST(a_read_reaches_output, i_clk, i_rst_n, ((r_state == ST_READ) && (!r_out_valid || m_axis_tready)) |=> m_axis_tvalid, "read result not presented")

endmodule

// File: src/lngh_ram.sv
module lngh_ram #(
    parameter int DEPTH = 26,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
